// ===== rtl/rwwf_pkg.sv =====
`default_nettype none

package rwwf_pkg;

    localparam int KERNEL_SIZE        = 5;
    localparam int MAX_WIDTH          = 1024;
    localparam int WEIGHT_TABLE_DEPTH = 256;
    localparam int HEIGHT_LIMIT       = 4096;

    localparam int WIN_LO = (KERNEL_SIZE - 1) / 2;
    localparam int WIN_HI = KERNEL_SIZE - 1 - WIN_LO;
    localparam int WIN_N  = KERNEL_SIZE * KERNEL_SIZE;

    localparam int QUEUE_DEPTH = 2;
    // Row slots cover the longest span between a pending pixel and the newest write,
    // plus the writes that queued jobs let the front run ahead.
    localparam int ROW_SLOTS = 2 * WIN_HI + QUEUE_DEPTH + 1;
    localparam int MEM_DEPTH = ROW_SLOTS * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SLOT_W    = $clog2(ROW_SLOTS);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
    localparam int KC_W      = $clog2(KERNEL_SIZE);

    localparam int WID_W     = 11;
    localparam int HGT_W     = 13;
    localparam int SCALE_W   = 16;
    localparam int REG_IDX_W = 2;

    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int DIST_W    = 18;
    localparam int WT_W      = 16;
    localparam int IDX_SHIFT = 12;
    localparam int PROD_W    = DIST_W + SCALE_W;
    localparam int IDX_W     = PROD_W - IDX_SHIFT;
    localparam int TAB_W     = $clog2(WEIGHT_TABLE_DEPTH);
    localparam int ACC_W     = WT_W + CHAN_W + $clog2(WIN_N);
    localparam int WSUM_W    = WT_W + $clog2(WIN_N);
    localparam int BIT_W     = $clog2(CHAN_W);
    localparam int PEND_W    = $clog2(WIN_HI * MAX_WIDTH + WIN_HI + 2);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE  = 2'd2;

    // exp(-1/16) in Q0.32
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

    typedef logic [WEIGHT_TABLE_DEPTH-1:0][WT_W-1:0] wtab_t;

    function automatic wtab_t build_weight_table();
        logic [63:0] a;
        logic [63:0] v;
        wtab_t       t;
        a = 64'd1 << 32;
        for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++)
        begin
            v    = (a + (64'd1 << 15)) >> 16;
            t[i] = (v > 64'd65535) ? {WT_W{1'b1}} : v[WT_W-1:0];
            a    = (a * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam wtab_t WEIGHT_TABLE = build_weight_table();

    typedef struct packed {
        logic [SLOT_W-1:0] start_slot;
        logic [COL_W-1:0]  start_col;
        logic [SLOT_W-1:0] centre_slot;
        logic [COL_W-1:0]  centre_col;
        logic              interior;
        logic              last;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } lb_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } lb_rd_t;

    function automatic logic [ADDR_W-1:0] lb_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [COL_W-1:0]  col);
        return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/range_weighted_window_filter.sv =====
`default_nettype none

// Flow: a border pixel's job reads its centre and passes it straight out; an interior
// pixel reads its centre, then one window word per cycle from the single read port of
// the line buffer, then passes 4 pipeline stages and 8 divide steps. The back takes one
// job at a time and holds it until the output takes its result; the 2-deep job queue
// lets input run ahead. Reset: sizes 640x480, range_scale 36, counters and queue
// cleared; line buffer holds no reset value and is read only once written.
module range_weighted_window_filter
    import rwwf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // blue_in, green_in, red_in
    input  wire logic                  s_tuser,   // opcode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [PIX_W-1:0]           m_tdata,   // blue_out, green_out, red_out
    output logic                       m_tlast,   // last_of_frame
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [SCALE_W-1:0]    cfg_data
);

    lb_wr_t             wr;
    lb_rd_t             rd;
    logic [PIX_W-1:0]   rd_data;
    logic               job_valid, job_pop, back_idle;
    job_t               job;
    logic [SCALE_W-1:0] range_scale;

    rwwf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .back_idle   (back_idle),
        .job_valid   (job_valid),
        .job         (job),
        .job_pop     (job_pop),
        .wr          (wr),
        .range_scale (range_scale)
    );

    rwwf_line_buf u_line_buf (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    rwwf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_scale (range_scale),
        .job_valid   (job_valid),
        .job         (job),
        .job_pop     (job_pop),
        .back_idle   (back_idle),
        .rd          (rd),
        .rd_data     (rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/rwwf_line_buf.sv =====
`default_nettype none

module rwwf_line_buf
    import rwwf_pkg::*;
(
    input  wire logic             clk,
    input  wire lb_wr_t           wr,
    input  wire lb_rd_t           rd,
    output logic [PIX_W-1:0]      rd_data
);

    logic [PIX_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rwwf_front.sv =====
`default_nettype none

module rwwf_front
    import rwwf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // blue_in, green_in, red_in
    input  wire logic                  s_tuser,   // opcode
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [SCALE_W-1:0]    cfg_data,
    input  wire logic                  back_idle,
    output logic                       job_valid,
    output job_t                       job,
    input  wire logic                  job_pop,
    output lb_wr_t                     wr,
    output logic [SCALE_W-1:0]         range_scale
);

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    logic [WID_W-1:0]   width_reg, width_next;
    logic [HGT_W-1:0]   height_reg, height_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [SLOT_W-1:0]  wslot_reg, wslot_next;
    logic [PEND_W-1:0]  pending_reg, pending_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [QP_W-1:0]    wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [QC_W-1:0]    q_count_reg, q_count_next;
    job_t               q_mem [QUEUE_DEPTH];

    logic [WID_W-1:0]   width_eff;
    logic [HGT_W-1:0]   height_eff;
    logic [PEND_W-1:0]  delay;
    logic               frame_start, frame_done, accept, is_pixel, push;
    logic [PEND_W-1:0]  pend_base, pend_inc;
    logic [SLOT_W-1:0]  wslot_base;
    job_t               job_in;

    always_comb
    begin
        if (width_reg == '0)
            width_eff = WID_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            width_eff = WID_W'(MAX_WIDTH);
        else
            width_eff = width_reg;
        if (height_reg == '0)
            height_eff = HGT_W'(1);
        else if (int'(height_reg) > HEIGHT_LIMIT)
            height_eff = HGT_W'(HEIGHT_LIMIT);
        else
            height_eff = height_reg;
    end

    assign delay = PEND_W'(width_eff) * PEND_W'(WIN_HI) + PEND_W'(WIN_HI);

    assign frame_start = (col_reg == '0) && (row_reg == '0);
    assign frame_done  = frame_start && (pending_reg != '0);
    // A new frame restarts the row slots, so wait until the back has let go of the buffer.
    assign s_tready    = (q_count_reg != QC_W'(QUEUE_DEPTH)) &&
                         (!frame_start || (back_idle && (q_count_reg == '0)));
    assign accept      = s_tvalid && s_tready;
    assign is_pixel    = (s_tuser == OP_PIXEL);
    assign cfg_ready   = 1'b1;
    assign range_scale = scale_reg;

    // Job for the oldest pending pixel
    always_comb
    begin
        job_in.centre_slot = out_slot_reg;
        job_in.centre_col  = out_col_reg;
        job_in.start_col   = out_col_reg - COL_W'(WIN_LO);
        if (int'(out_slot_reg) >= WIN_LO)
            job_in.start_slot = out_slot_reg - SLOT_W'(WIN_LO);
        else
            job_in.start_slot = SLOT_W'(int'(out_slot_reg) + ROW_SLOTS - WIN_LO);
        job_in.interior = (int'(out_row_reg) >= WIN_LO) &&
                          (int'(out_row_reg) + WIN_HI < int'(height_eff)) &&
                          (int'(out_col_reg) >= WIN_LO) &&
                          (int'(out_col_reg) + WIN_HI < int'(width_eff));
        job_in.last = (int'(out_col_reg) == int'(width_eff) - 1) &&
                      (int'(out_row_reg) == int'(height_eff) - 1);
    end

    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        scale_next    = scale_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        wslot_next    = wslot_reg;
        pending_next  = pending_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        push          = 1'b0;
        pend_base     = frame_start ? '0 : pending_reg;
        pend_inc      = pend_base + PEND_W'(1);
        wslot_base    = frame_start ? '0 : wslot_reg;
        wr.en         = 1'b0;
        wr.addr       = lb_addr(wslot_base, col_reg);
        wr.data       = s_tdata;

        if (accept && is_pixel)
        begin
            wr.en = 1'b1;
            if (frame_start)
            begin
                out_col_next  = '0;
                out_row_next  = '0;
                out_slot_next = '0;
            end
            if (pend_inc > delay)
            begin
                push         = 1'b1;
                pending_next = pend_base;
            end
            else
            begin
                pending_next = pend_inc;
            end
            wslot_next = wslot_base;
            if (int'(col_reg) + 1 == int'(width_eff))
            begin
                col_next = '0;
                if (int'(row_reg) + 1 >= int'(height_eff))
                    row_next = '0;
                else
                    row_next = row_reg + ROW_W'(1);
                wslot_next = (int'(wslot_base) == ROW_SLOTS - 1) ? '0
                                                                 : wslot_base + SLOT_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        else if (accept && frame_done)
        begin
            push         = 1'b1;
            pending_next = pending_reg - PEND_W'(1);
        end

        // Step to the next output position
        if (push)
        begin
            if (int'(out_col_reg) + 1 == int'(width_eff))
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + ROW_W'(1);
                out_slot_next = (int'(out_slot_reg) == ROW_SLOTS - 1) ? '0
                                                                      : out_slot_reg + SLOT_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:
                begin
                    width_next   = cfg_data[WID_W-1:0];
                    col_next     = '0;
                    row_next     = '0;
                    pending_next = '0;
                end
                REG_HEIGHT:
                begin
                    height_next  = cfg_data[HGT_W-1:0];
                    col_next     = '0;
                    row_next     = '0;
                    pending_next = '0;
                end
                REG_SCALE:
                begin
                    scale_next = cfg_data;
                end
                default:
                begin
                    scale_next = scale_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        q_count_next = q_count_reg;
        if (push)
            wptr_next = (int'(wptr_reg) == QUEUE_DEPTH - 1) ? '0 : wptr_reg + QP_W'(1);
        if (job_pop)
            rptr_next = (int'(rptr_reg) == QUEUE_DEPTH - 1) ? '0 : rptr_reg + QP_W'(1);
        if (push && !job_pop)
            q_count_next = q_count_reg + QC_W'(1);
        else if (!push && job_pop)
            q_count_next = q_count_reg - QC_W'(1);
    end

    assign job_valid = (q_count_reg != '0);
    assign job       = q_mem[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WID_W'(640);
            height_reg   <= HGT_W'(480);
            scale_reg    <= SCALE_W'(36);
            col_reg      <= '0;
            row_reg      <= '0;
            wslot_reg    <= '0;
            pending_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            scale_reg    <= scale_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            wslot_reg    <= wslot_next;
            pending_reg  <= pending_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            q_count_reg  <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= job_in;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(q_count_reg) <= QUEUE_DEPTH)
        else $error("job queue overfilled");

    a_frame_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_pixel && frame_start |-> back_idle && (q_count_reg == '0))
        else $error("new frame written while back still reads the buffer");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (q_count_reg != '0))
        else $error("pop from empty job queue");

endmodule

`default_nettype wire

// ===== rtl/rwwf_back.sv =====
`default_nettype none

module rwwf_back
    import rwwf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SCALE_W-1:0]  range_scale,
    input  wire logic                job_valid,
    input  wire job_t                job,
    output logic                     job_pop,
    output logic                     back_idle,
    output lb_rd_t                   rd,
    input  wire logic [PIX_W-1:0]    rd_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [PIX_W-1:0]         m_tdata,   // blue_out, green_out, red_out
    output logic                     m_tlast    // last_of_frame
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_WINDOW,
        ST_FLUSH,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic [PIX_W-1:0]   centre_reg, centre_next;
    logic [PIX_W-1:0]   res_reg, res_next;
    logic [KC_W-1:0]    row_cnt_reg, row_cnt_next, col_cnt_reg, col_cnt_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               v0_reg, v0_next, va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next;
    logic               m_tvalid_reg, m_tvalid_next, m_tlast_reg, m_tlast_next;
    logic [PIX_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;

    // datapath
    logic [DIST_W-1:0]  dist_reg;
    logic [PIX_W-1:0]   pix_a_reg, pix_b_reg, pix_c_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WT_W-1:0]    wt_reg;
    logic [ACC_W-1:0]   acc_reg [3];
    logic [WSUM_W-1:0]  wsum_reg;
    logic [ACC_W-1:0]   rem_reg [3];
    logic [CHAN_W-1:0]  quo_reg [3];

    logic [DIST_W-1:0]  dist_sum;
    logic [CHAN_W-1:0]  ad;
    logic [PROD_W-1:0]  prod_b;
    logic [WT_W-1:0]    wt_c;
    logic [WT_W+CHAN_W-1:0] mac [3];
    logic [ACC_W-1:0]   trial;
    logic [ACC_W-1:0]   rem_step [3];
    logic [CHAN_W-1:0]  quo_step [3];
    logic               pipe_empty, acc_clr, div_start;

    assign pipe_empty = !v0_reg && !va_reg && !vb_reg && !vc_reg;
    assign job_pop    = (state_reg == ST_IDLE) && job_valid;
    assign back_idle  = (state_reg == ST_IDLE);
    assign acc_clr    = (state_reg == ST_CENTRE);
    assign div_start  = (state_reg == ST_FLUSH) && pipe_empty && (wsum_reg != '0);

    always_comb
    begin
        rd.en = job_pop || (state_reg == ST_WINDOW);
        if (job_pop)
            rd.addr = lb_addr(job.centre_slot, job.centre_col);
        else
            rd.addr = lb_addr(slot_reg, job_reg.start_col + COL_W'(col_cnt_reg));
    end

    // Squared colour distance of the word just read
    always_comb
    begin
        dist_sum = '0;
        ad       = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (rd_data[k*CHAN_W +: CHAN_W] >= centre_reg[k*CHAN_W +: CHAN_W])
                ad = rd_data[k*CHAN_W +: CHAN_W] - centre_reg[k*CHAN_W +: CHAN_W];
            else
                ad = centre_reg[k*CHAN_W +: CHAN_W] - rd_data[k*CHAN_W +: CHAN_W];
            dist_sum = dist_sum + DIST_W'(ad) * DIST_W'(ad);
        end
    end

    assign prod_b = PROD_W'(dist_reg) * PROD_W'(range_scale);
    assign wt_c   = (idx_reg < IDX_W'(WEIGHT_TABLE_DEPTH)) ? WEIGHT_TABLE[idx_reg[TAB_W-1:0]]
                                                         : '0;

    always_comb
    begin
        trial = ACC_W'(wsum_reg) << bit_reg;
        for (int k = 0; k < 3; k++)
        begin
            mac[k]      = (WT_W+CHAN_W)'(wt_reg) * (WT_W+CHAN_W)'(pix_c_reg[k*CHAN_W +: CHAN_W]);
            quo_step[k] = quo_reg[k];
            rem_step[k] = rem_reg[k];
            if (rem_reg[k] >= trial)
            begin
                rem_step[k]          = rem_reg[k] - trial;
                quo_step[k][bit_reg] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        centre_next   = centre_reg;
        res_next      = res_reg;
        row_cnt_next  = row_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        slot_next     = slot_reg;
        bit_next      = bit_reg;
        v0_next       = (state_reg == ST_WINDOW);
        va_next       = v0_reg;
        vb_next       = va_reg;
        vc_next       = vb_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next   = job;
                    state_next = ST_CENTRE;
                end
            end
            ST_CENTRE:
            begin
                centre_next = rd_data;
                if (job_reg.interior)
                begin
                    row_cnt_next = '0;
                    col_cnt_next = '0;
                    slot_next    = job_reg.start_slot;
                    state_next   = ST_WINDOW;
                end
                else
                begin
                    res_next   = rd_data;
                    state_next = ST_DONE;
                end
            end
            ST_WINDOW:
            begin
                if (int'(col_cnt_reg) == KERNEL_SIZE - 1)
                begin
                    col_cnt_next = '0;
                    slot_next    = (int'(slot_reg) == ROW_SLOTS - 1) ? '0
                                                                     : slot_reg + SLOT_W'(1);
                    if (int'(row_cnt_reg) == KERNEL_SIZE - 1)
                        state_next = ST_FLUSH;
                    else
                        row_cnt_next = row_cnt_reg + KC_W'(1);
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + KC_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (pipe_empty)
                begin
                    if (wsum_reg == '0)
                    begin
                        res_next   = centre_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bit_next   = BIT_W'(CHAN_W - 1);
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    res_next   = {quo_step[2], quo_step[1], quo_step[0]};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tlast_next  = job_reg.last;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            job_reg      <= '0;
            centre_reg   <= '0;
            res_reg      <= '0;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            slot_reg     <= '0;
            bit_reg      <= '0;
            v0_reg       <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            job_reg      <= job_next;
            centre_reg   <= centre_next;
            res_reg      <= res_next;
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            slot_reg     <= slot_next;
            bit_reg      <= bit_next;
            v0_reg       <= v0_next;
            va_reg       <= va_next;
            vb_reg       <= vb_next;
            vc_reg       <= vc_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    // Weight pipeline: distance, table index, weight, accumulate; then the divider
    always_ff @(posedge clk)
    begin
        dist_reg  <= dist_sum;
        pix_a_reg <= rd_data;
        idx_reg   <= prod_b[PROD_W-1:IDX_SHIFT];
        pix_b_reg <= pix_a_reg;
        wt_reg    <= wt_c;
        pix_c_reg <= pix_b_reg;
        if (acc_clr)
        begin
            wsum_reg <= '0;
            for (int k = 0; k < 3; k++)
                acc_reg[k] <= '0;
        end
        else if (vc_reg)
        begin
            wsum_reg <= wsum_reg + WSUM_W'(wt_reg);
            for (int k = 0; k < 3; k++)
                acc_reg[k] <= acc_reg[k] + ACC_W'(mac[k]);
        end
        if (div_start)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k] <= acc_reg[k];
                quo_reg[k] <= '0;
            end
        end
        else if (state_reg == ST_DIVIDE)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k] <= rem_step[k];
                quo_reg[k] <= quo_step[k];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_div_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> pipe_empty)
        else $error("divide started with weights still in flight");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE && bit_reg == '0 |=> state_reg == ST_DONE)
        else $error("divider did not finish on its last bit");

endmodule

`default_nettype wire
